>>> rtl/brpe_pkg.sv
// Shared types and constants for the bitmap row pixel expander.
package brpe_pkg;

    localparam int P_PALETTE_DEPTH = 256;
    localparam int P_MAX_LEDS      = 256;
    localparam int P_MAX_COPIES    = 8;

    localparam int CFG_DW = 9;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_LED_COUNT  = 2'd2;

    localparam logic [1:0] MODE_1BPP  = 2'd0;
    localparam logic [1:0] MODE_4BPP  = 2'd1;
    localparam logic [1:0] MODE_8BPP  = 2'd2;
    localparam logic [1:0] MODE_24BPP = 2'd3;

    localparam logic       REQ_PIXEL   = 1'b0;
    localparam logic       REQ_PALETTE = 1'b1;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef struct packed {
        logic        req_type;
        logic        row_start;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } t_in_word;

    typedef struct packed {
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIX,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/bitmap_row_pixel_expander_core.sv
// Bitmap row pixel expander: unpacks row bytes, palette lookup, LED fan-out.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per pixel byte
// or palette write. A word is taken when valid is high and stall is low; stall
// is low only while the block is idle, so one word is worked on at a time.
// Palette writes give no result; contents are undefined until written.
// A pixel byte yields 8, 2 or 1 pixels (1, 4, 8 bpp) or one pixel on every
// third byte (24 bpp). Each 1, 4 or 8 bpp pixel is read from the palette (one
// synchronous read port) in the PIX state; the EMIT state then gives one
// result per LED copy, up to MAX_COPIES; a pixel with no copies gives none.
// Output channel (o_out_valid / i_out_stall / o_out_word): one result register;
// while the receiver stalls the word holds and the block waits. last marks the
// final result of a byte.
// Config port: i_cfg_we with i_cfg_idx (0 mode, 1 row width, 2 LED count), to
// be written by the user only while idle; the block does not enforce this.
// Synchronous reset clears row state and config to 8 bpp, width 1, one LED.
module bitmap_row_pixel_expander_core #(
    parameter int PALETTE_DEPTH = brpe_pkg::P_PALETTE_DEPTH,
    parameter int MAX_LEDS      = brpe_pkg::P_MAX_LEDS,
    parameter int MAX_COPIES    = brpe_pkg::P_MAX_COPIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [brpe_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [brpe_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  brpe_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output brpe_pkg::t_out_word          o_out_word
);
    import brpe_pkg::*;

    localparam int AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW      = $clog2(MAX_COPIES + 1);
    localparam int LIM_CAP = (MAX_LEDS > 511) ? 511 : MAX_LEDS;

    logic [23:0]  r_palette [PALETTE_DEPTH];
    logic [23:0]  r_rd_data;

    t_state       r_state, n_state;
    logic [1:0]   r_mode;
    logic [8:0]   r_row_width;
    logic [8:0]   r_led_count;
    logic [8:0]   r_col;
    logic [1:0]   r_phase;
    logic [15:0]  r_partial;
    logic [7:0]   r_byte;
    logic [3:0]   r_pix_left;
    logic         r_direct;
    logic         r_oob;
    logic [23:0]  r_rgb;
    logic [CW-1:0] r_copy;
    logic [9:0]   r_led;
    logic         r_out_valid;
    t_out_word    r_out_word;

    logic         in_take, pal_we, mem_rd, out_load, out_free;
    logic [8:0]   limit;
    logic         pix_yield, more_copy, more_pix;
    logic [9:0]   led_next, col_inc;
    logic [CW-1:0] copy_inc;
    logic [7:0]   pix_idx;
    logic         pix_oob;
    logic [7:0]   byte_shift;
    logic [23:0]  colour;
    logic         pal_in_range;

    logic [8:0]   col0;
    logic [1:0]   phase0;
    logic [15:0]  partial0;

    assign limit    = (r_led_count > 9'(LIM_CAP)) ? 9'(LIM_CAP) : r_led_count;
    assign out_free = !r_out_valid || !i_out_stall;
    assign col_inc  = {1'b0, r_col} + 10'd1;
    assign led_next = r_led + {1'b0, r_row_width};
    assign copy_inc = r_copy + 1'b1;

    assign pix_yield = (r_col < r_row_width) && (r_col < limit);
    assign more_copy = (copy_inc < CW'(MAX_COPIES)) && (led_next < {1'b0, limit});
    assign more_pix  = (r_pix_left > 4'd1) && (col_inc < {1'b0, r_row_width})
                       && (col_inc < {1'b0, limit});

    assign pal_in_range = ({1'b0, i_in_word.palette_index} < 9'(PALETTE_DEPTH));
    assign pix_oob      = ({1'b0, pix_idx} >= 9'(PALETTE_DEPTH));

    always_comb begin
        case (r_mode)
            MODE_1BPP: begin
                pix_idx    = {7'd0, r_byte[7]};
                byte_shift = {r_byte[6:0], 1'b0};
            end
            MODE_4BPP: begin
                pix_idx    = {4'd0, r_byte[7:4] & NIBBLE_MASK};
                byte_shift = {r_byte[3:0], 4'd0};
            end
            default: begin
                pix_idx    = r_byte;
                byte_shift = r_byte;
            end
        endcase
    end

    assign colour = r_direct ? r_rgb : (r_oob ? 24'd0 : r_rd_data);

    assign col0     = i_in_word.row_start ? 9'd0  : r_col;
    assign phase0   = i_in_word.row_start ? 2'd0  : r_phase;
    assign partial0 = i_in_word.row_start ? 16'd0 : r_partial;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && i_in_word.req_type == REQ_PIXEL) begin
                    n_state = ST_PIX;
                end
            end
            ST_PIX: begin
                if (r_pix_left == 4'd0) begin
                    n_state = ST_IDLE;
                end else if (pix_yield) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && !more_copy) begin
                    n_state = ST_PIX;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        in_take    = 1'b0;
        pal_we     = 1'b0;
        mem_rd     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
                pal_we     = i_in_valid && i_in_word.req_type == REQ_PALETTE && pal_in_range;
            end
            ST_PIX: begin
                mem_rd = (r_pix_left != 4'd0) && pix_yield && !r_direct;
            end
            ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[i_in_word.palette_index[AW-1:0]] <= i_in_word.palette_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_rd_data <= r_palette[pix_idx[AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_8BPP;
            r_row_width <= 9'd1;
            r_led_count <= 9'd1;
            r_col       <= 9'd0;
            r_phase     <= 2'd0;
            r_partial   <= 16'd0;
            r_pix_left  <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PIXEL_MODE: r_mode      <= i_cfg_data[1:0];
                    CFG_ROW_WIDTH:  r_row_width <= i_cfg_data;
                    CFG_LED_COUNT:  r_led_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take && i_in_word.req_type == REQ_PIXEL) begin
                r_col <= col0;
                case (r_mode)
                    MODE_1BPP: begin
                        r_phase <= 2'd0; r_partial <= 16'd0; r_pix_left <= 4'd8;
                    end
                    MODE_4BPP: begin
                        r_phase <= 2'd0; r_partial <= 16'd0; r_pix_left <= 4'd2;
                    end
                    MODE_8BPP: begin
                        r_phase <= 2'd0; r_partial <= 16'd0; r_pix_left <= 4'd1;
                    end
                    default: begin
                        if (phase0 == 2'd0) begin
                            r_phase    <= 2'd1;
                            r_partial  <= {8'd0, i_in_word.data_byte};
                            r_pix_left <= 4'd0;
                        end else if (phase0 == 2'd1) begin
                            r_phase    <= 2'd2;
                            r_partial  <= {i_in_word.data_byte, partial0[7:0]};
                            r_pix_left <= 4'd0;
                        end else begin
                            r_phase    <= 2'd0;
                            r_partial  <= 16'd0;
                            r_pix_left <= 4'd1;
                        end
                    end
                endcase
            end else if (r_state == ST_PIX && r_pix_left != 4'd0 && !pix_yield) begin
                if (r_col < r_row_width) begin
                    r_col <= col_inc[8:0];
                end
                r_pix_left <= r_pix_left - 4'd1;
            end else if (out_load && !more_copy) begin
                r_col      <= col_inc[8:0];
                r_pix_left <= r_pix_left - 4'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte   <= i_in_word.data_byte;
            r_direct <= (r_mode == MODE_24BPP);
            r_rgb    <= {i_in_word.data_byte, partial0};
        end else if ((r_state == ST_PIX && r_pix_left != 4'd0 && !pix_yield)
                     || (out_load && !more_copy)) begin
            r_byte <= byte_shift;
        end
        if (r_state == ST_PIX && pix_yield) begin
            r_copy <= '0;
            r_led  <= {1'b0, r_col};
            r_oob  <= pix_oob;
        end else if (out_load && more_copy) begin
            r_copy <= copy_inc;
            r_led  <= led_next;
        end
        if (out_load) begin
            r_out_word.led_index <= r_led[7:0];
            r_out_word.red       <= colour[23:16];
            r_out_word.green     <= colour[15:8];
            r_out_word.blue      <= colour[7:0];
            r_out_word.last      <= !(more_copy || more_pix);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_emit_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> (r_col < r_row_width && r_led < {1'b0, limit}))
        else $error("emitting outside the row or LED range");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !(more_copy || more_pix)) |=> r_state != ST_EMIT)
        else $error("further result after last");

    a_pix_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_left <= 4'd8)
        else $error("pixel count out of range");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("output word overwritten while stalled");
`endif

endmodule

>>> verif/bitmap_row_pixel_expander_core_tb.sv
// Self-checking testbench for the bitmap row pixel expander core.
`timescale 1ns / 100ps

module bitmap_row_pixel_expander_core_tb;
    import brpe_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_ITEMS   = 160;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int ROW_BYTE_CAP   = 24;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx   = CFG_PIXEL_MODE;
    logic [CFG_DW-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in_word   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_word;

    logic [23:0] palette_mdl [P_PALETTE_DEPTH];
    logic [7:0]  palette_used[$];
    int          col_mdl     = 0;
    int          phase_mdl   = 0;
    logic [15:0] partial_mdl = '0;
    logic [1:0]  mode_mdl    = MODE_8BPP;
    int          width_mdl   = 1;
    int          leds_mdl    = 1;

    t_out_word   led_writes_due[$];
    t_out_word   pixel_copies[$];

    int fail_count      = 0;
    int words_sent      = 0;
    int palette_sent    = 0;
    int results_checked = 0;
    int in_idle_pct     = 9;
    int out_idle_pct    = 9;
    int hold_request    = 0;

    bitmap_row_pixel_expander_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // fan one pixel out to its LED copies at the current column
    function automatic void place_pixel(logic [23:0] rgb);
        int        lim;
        int        led;
        t_out_word w;
        lim = (leds_mdl < P_MAX_LEDS) ? leds_mdl : P_MAX_LEDS;
        if (col_mdl >= width_mdl) return;
        for (int i = 0; i < P_MAX_COPIES; i++) begin
            led = col_mdl + i * width_mdl;
            if (led >= lim) break;
            w.led_index = led[7:0];
            w.red       = rgb[23:16];
            w.green     = rgb[15:8];
            w.blue      = rgb[7:0];
            w.last      = 1'b0;
            pixel_copies.push_back(w);
        end
        col_mdl++;
    endfunction

    function automatic void predict_word(t_in_word w);
        logic [7:0] b;
        t_out_word  r;
        b = w.data_byte;
        if (w.req_type == REQ_PALETTE) begin
            palette_mdl[w.palette_index] = w.palette_color;
            palette_used.push_back(w.palette_index);
            return;
        end
        if (w.row_start) begin
            col_mdl     = 0;
            phase_mdl   = 0;
            partial_mdl = '0;
        end
        pixel_copies.delete();
        if (mode_mdl != MODE_24BPP) begin
            phase_mdl   = 0;
            partial_mdl = '0;
        end
        case (mode_mdl)
            MODE_1BPP: begin
                for (int k = 7; k >= 0; k--) place_pixel(palette_mdl[{7'd0, b[k]}]);
            end
            MODE_4BPP: begin
                place_pixel(palette_mdl[{4'd0, b[7:4]}]);
                place_pixel(palette_mdl[{4'd0, b[3:0] & NIBBLE_MASK}]);
            end
            MODE_8BPP: begin
                place_pixel(palette_mdl[b]);
            end
            MODE_24BPP: begin
                if (phase_mdl == 0) begin
                    partial_mdl = {8'h00, b};
                    phase_mdl   = 1;
                end else if (phase_mdl == 1) begin
                    partial_mdl[15:8] = b;
                    phase_mdl         = 2;
                end else begin
                    place_pixel({b, partial_mdl});
                    phase_mdl   = 0;
                    partial_mdl = '0;
                end
            end
        endcase
        foreach (pixel_copies[i]) begin
            r      = pixel_copies[i];
            r.last = (i == pixel_copies.size() - 1);
            led_writes_due.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(t_out_word got);
        t_out_word want;
        if (led_writes_due.size() == 0) begin
            $error("result with nothing due: led_index %0d rgb %02h%02h%02h",
                   got.led_index, got.red, got.green, got.blue);
            fail_count++;
            return;
        end
        want = led_writes_due.pop_front();
        results_checked++;
        compare_field("led_index", want.led_index, got.led_index);
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction

    function automatic t_in_word pixel_word(logic start, logic [7:0] b);
        t_in_word w;
        w.req_type      = REQ_PIXEL;
        w.row_start     = start;
        w.data_byte     = b;
        w.palette_index = 8'($urandom_range(255));
        w.palette_color = 24'($urandom_range(24'hFFFFFF));
        return w;
    endfunction

    function automatic t_in_word palette_word(logic [7:0] idx, logic [23:0] colour);
        t_in_word w;
        w.req_type      = REQ_PALETTE;
        w.row_start     = 1'($urandom_range(1));
        w.data_byte     = 8'($urandom_range(255));
        w.palette_index = idx;
        w.palette_color = colour;
        return w;
    endfunction

    // 8 bpp bytes index only palette entries already written
    function automatic logic [7:0] pixel_byte();
        if (mode_mdl == MODE_8BPP)
            return palette_used[$urandom_range(palette_used.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // called on a rising edge; returns on the edge the word is taken
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        predict_word(w);
        words_sent++;
        if (w.req_type == REQ_PALETTE) palette_sent++;
    endtask

    // sender pauses until every due result is in and the block has gone quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (led_writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_PIXEL_MODE: mode_mdl  = value[1:0];
            CFG_ROW_WIDTH:  width_mdl = int'(value[CFG_DW-1:0]);
            CFG_LED_COUNT:  leds_mdl  = int'(value[CFG_DW-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input int width, input int leds);
        drain();
        write_reg(CFG_PIXEL_MODE, int'(mode));
        write_reg(CFG_ROW_WIDTH, width);
        write_reg(CFG_LED_COUNT, leds);
    endtask

    function automatic int bytes_per_row();
        int n;
        case (mode_mdl)
            MODE_1BPP: n = (width_mdl + 7) / 8;
            MODE_4BPP: n = (width_mdl + 1) / 2;
            MODE_8BPP: n = width_mdl;
            default:   n = 3 * width_mdl;
        endcase
        if (n < 1) n = 1;
        if (n > ROW_BYTE_CAP) n = ROW_BYTE_CAP;
        return n;
    endfunction

    // mostly whole rows; some short or padded, stray row starts, palette writes mixed in
    task automatic send_rows(input int n_items);
        int sent;
        int row_len;
        sent = 0;
        while (sent < n_items) begin
            row_len = bytes_per_row();
            if ($urandom_range(9) == 0) row_len = $urandom_range(1, row_len + 2);
            for (int k = 0; k < row_len && sent < n_items; k++) begin
                if ($urandom_range(9) == 0)
                    send_word(palette_word(8'($urandom_range(255)),
                                           24'($urandom_range(24'hFFFFFF))));
                send_word(pixel_word((k == 0) ^ ($urandom_range(19) == 0),
                                     pixel_byte()));
                sent++;
            end
        end
    endtask

    // low sixteen entries serve 1 and 4 bpp; a few more for the 8 bpp cases
    task automatic test_palette_fill();
        for (int i = 0; i < 16; i++) begin
            if (i == 0)
                send_word(palette_word(8'd0, 24'h000000));
            else
                send_word(palette_word(i[7:0], 24'($urandom_range(24'hFFFFFF))));
        end
        send_word(palette_word(8'h12, 24'($urandom_range(24'hFFFFFF))));
        send_word(palette_word(8'h34, 24'($urandom_range(24'hFFFFFF))));
        send_word(palette_word(8'hFF, 24'hFFFFFF));
    endtask

    task automatic test_directed();
        // settings straight out of reset: 8 bpp, one column, one LED
        send_word(pixel_word(1'b1, 8'h00));
        send_word(pixel_word(1'b0, 8'hFF));
        send_word(pixel_word(1'b1, 8'hFF));
        set_config(MODE_1BPP, 8, 64);
        send_word(pixel_word(1'b1, 8'hA5));
        send_word(pixel_word(1'b0, 8'h5A));
        set_config(MODE_4BPP, 3, 256);
        send_word(pixel_word(1'b1, 8'hF0));
        send_word(palette_word(8'h0F, 24'($urandom_range(24'hFFFFFF))));
        send_word(pixel_word(1'b0, 8'h0F));
        set_config(MODE_24BPP, 2, 5);
        send_word(pixel_word(1'b1, 8'h11));
        send_word(pixel_word(1'b0, 8'h22));
        send_word(palette_word(8'h80, 24'($urandom_range(24'hFFFFFF))));
        send_word(pixel_word(1'b0, 8'h33));
        send_word(pixel_word(1'b0, 8'h44));
        send_word(pixel_word(1'b0, 8'h55));
        send_word(pixel_word(1'b0, 8'h66));
        send_word(pixel_word(1'b1, 8'h77));
        send_word(pixel_word(1'b1, 8'hFF));
        send_word(pixel_word(1'b0, 8'h00));
        send_word(pixel_word(1'b0, 8'hFF));
        set_config(MODE_8BPP, 0, 256);
        send_word(pixel_word(1'b1, 8'h12));
        set_config(MODE_8BPP, 511, 511);
        send_word(pixel_word(1'b1, 8'h34));
        set_config(MODE_1BPP, 1, 0);
        send_word(pixel_word(1'b1, 8'hFF));
        set_config(MODE_8BPP, 256, 256);
        send_word(pixel_word(1'b1, 8'hFF));
    endtask

    task automatic test_no_gaps();
        drain();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_config(MODE_4BPP, 4, 32);
        send_rows(40);
        drain();
        in_idle_pct  = 9;
        out_idle_pct = 9;
    endtask

    // full 1 bpp bytes at eight copies each while the output is held off
    task automatic test_backpressure();
        set_config(MODE_1BPP, 8, 64);
        hold_request = HOLD_OFF_LEN;
        for (int i = 0; i < 12; i++) send_word(pixel_word(1'b1, 8'($urandom_range(255))));
        drain();
    endtask

    task automatic test_random();
        int first;
        int r;
        int width;
        int leds;
        first = words_sent;
        while (words_sent - first < RANDOM_ITEMS) begin
            r = $urandom_range(19);
            width = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? 511 : $urandom_range(1, 16);
            r = $urandom_range(19);
            leds = (r == 0) ? 0 : (r == 1) ? 511 : (r == 2) ? 256 : $urandom_range(1, 128);
            set_config(2'($urandom_range(3)), width, leds);
            send_rows($urandom_range(15, 35));
        end
    endtask

    initial begin : out_side
        int        hold_left;
        logic      took;
        t_out_word seen;
        hold_left = 0;
        took      = 1'b0;
        seen      = '0;
        forever begin
            @(posedge i_clk);
            if (took) check_result(seen);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
            @(negedge i_clk);
            took = i_rst_n && o_out_valid && !i_out_stall;
            seen = o_out_word;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, led_writes_due.size());
        $display("bitmap_row_pixel_expander_core_tb: done, errors");
        $finish;
    end

    initial begin : run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_palette_fill();
        test_directed();
        test_no_gaps();
        test_backpressure();
        test_random();
        drain();
        $display("%0d words sent (%0d palette writes), %0d LED results checked",
                 words_sent, palette_sent, results_checked);
        $display("covered 1/4/8/24 bpp, zero and oversized width and LED count, padding, %s",
                 "row restarts mid pixel, gapless and held-off output");
        if (fail_count == 0)
            $display("bitmap_row_pixel_expander_core_tb: done, clean");
        else
            $display("bitmap_row_pixel_expander_core_tb: done, errors");
        $finish;
    end

endmodule
